// ===== src/rle_palette_sprite_decoder_assert.svh =====
// assertion macros shared by the sprite decoder modules
// no dependencies; included by files that check their own logic
`ifndef RLE_PALETTE_SPRITE_DECODER_ASSERT_SVH
`define RLE_PALETTE_SPRITE_DECODER_ASSERT_SVH

// same-cycle implication under reset
`define RPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define RPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rps_pkg.sv =====
// types and constants for the run-length paletted sprite decoder
// no dependencies; used by every module of the block
`default_nettype none

package rps_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_STREAM = 1'b1;

	localparam logic REG_TRANSPARENT = 1'b0;
	localparam logic REG_SEMI = 1'b1;

	localparam logic [7:0] ALPHA_CLEAR = 8'd0;
	localparam logic [7:0] ALPHA_SEMI = 8'd127;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_TRANS,
		CMD_PIXEL
	} rps_kind_t;

	typedef struct packed {
		rps_kind_t kind;
		logic [7:0] data;
		logic [15:0] color;
		logic semi;
	} rps_cmd_t;

endpackage

`default_nettype wire

// ===== src/rps_front.sv =====
// front end: takes input words, tracks markers and runs, issues commands
// depends on rps_pkg
`default_nettype none

module rps_front
	import rps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic opcode,
	input wire logic [7:0] stream_byte,
	input wire logic [7:0] palette_address,
	input wire logic [15:0] palette_color,
	input wire logic [7:0] transparent_marker,
	input wire logic [7:0] semi_marker,
	input wire logic queue_full,
	output logic push,
	output rps_cmd_t cmd
);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_TCOUNT,
		MODE_SCOUNT,
		MODE_RUN
	} mode_t;

	mode_t mode_q, mode_d;
	logic [7:0] run_remaining_q, run_remaining_d;
	logic run_semi_q, run_semi_d;
	logic [7:0] rem_dec;

	assign in_ready = !queue_full;

	always_comb begin
		mode_d = mode_q;
		run_remaining_d = run_remaining_q;
		run_semi_d = run_semi_q;
		push = 1'b0;
		cmd = '0;
		rem_dec = run_remaining_q;
		if (in_valid && in_ready) begin
			if (opcode == OP_WRITE) begin
				push = 1'b1;
				cmd.kind = CMD_WRITE;
				cmd.data = palette_address;
				cmd.color = palette_color;
			end else begin
				unique case (mode_q)
					MODE_IDLE: begin
						if (stream_byte == transparent_marker) begin
							mode_d = MODE_TCOUNT;
						end else if (stream_byte == semi_marker) begin
							mode_d = MODE_SCOUNT;
						end else if (stream_byte != 8'd0) begin
							run_remaining_d = stream_byte;
							run_semi_d = 1'b0;
							mode_d = MODE_RUN;
						end
					end
					MODE_TCOUNT: begin
						mode_d = MODE_IDLE;
						if (stream_byte != 8'd0) begin
							push = 1'b1;
							cmd.kind = CMD_TRANS;
							cmd.data = stream_byte;
						end
					end
					MODE_SCOUNT: begin
						if (stream_byte == 8'd0) begin
							mode_d = MODE_IDLE;
						end else begin
							run_remaining_d = stream_byte;
							run_semi_d = 1'b1;
							mode_d = MODE_RUN;
						end
					end
					MODE_RUN: begin
						push = 1'b1;
						cmd.kind = CMD_PIXEL;
						cmd.data = stream_byte;
						cmd.semi = run_semi_q;
						if (run_remaining_q != 8'd0) begin
							rem_dec = run_remaining_q - 8'd1;
						end
						run_remaining_d = rem_dec;
						if (rem_dec == 8'd0) begin
							mode_d = MODE_IDLE;
						end
					end
					default: begin
						mode_d = MODE_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			run_remaining_q <= 8'd0;
			run_semi_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			run_remaining_q <= run_remaining_d;
			run_semi_q <= run_semi_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/rps_fifo.sv =====
// short command queue between the front end and the back end
// depends on rps_pkg and the assertion macro header
`default_nettype none

`include "rle_palette_sprite_decoder_assert.svh"

module rps_fifo
	import rps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire rps_cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output rps_cmd_t pop_cmd,
	output logic empty
);

	rps_cmd_t entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0] count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers wrap on their own at a power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	`RPS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1,
		count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count beyond depth")
	`RPS_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty, "pop from empty queue")
	`RPS_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full, "push into full queue")
	`RPS_ASSERT_NXT(a_count_up, clk, arst_n, push && !pop,
		count_q == $past(count_q) + (QUEUE_AW+1)'(1), "queue count did not grow")

endmodule

`default_nettype wire

// ===== src/rps_back.sv =====
// back end: palette memory, colour expansion and output register
// depends on rps_pkg and the assertion macro header
`default_nettype none

`include "rle_palette_sprite_decoder_assert.svh"

module rps_back
	import rps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire rps_cmd_t cmd,
	input wire logic queue_empty,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha,
	output logic [7:0] repeat_res
);

	logic [15:0] palette_mem [PALETTE_ENTRIES];

	logic valid_s1;
	rps_kind_t kind_s1;
	logic [7:0] data_s1;
	logic semi_s1;
	logic oob_s1;
	logic [15:0] rd_data_s1;

	logic out_valid_q;
	logic [7:0] red_q, green_q, blue_q, alpha_q, repeat_q;

	logic advance;
	logic cmd_in_range;
	logic [15:0] color;

	assign advance = !out_valid_q || out_ready;
	assign pop = !queue_empty && (!valid_s1 || advance);
	assign cmd_in_range = ({1'b0, cmd.data} < PAL_LIMIT);

	always_ff @(posedge clk) begin
		if (pop && cmd.kind == CMD_WRITE && cmd_in_range) begin
			palette_mem[cmd.data[PAL_AW-1:0]] <= cmd.color;
		end
		if (pop) begin
			rd_data_s1 <= palette_mem[cmd.data[PAL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= (cmd.kind != CMD_WRITE);
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1 <= cmd.kind;
			data_s1 <= cmd.data;
			semi_s1 <= cmd.semi;
			oob_s1 <= !cmd_in_range;
		end
	end

	// index past the palette reads as black
	assign color = oob_s1 ? 16'h0000 : rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			case (kind_s1)
				CMD_TRANS: begin
					red_q <= 8'd0;
					green_q <= 8'd0;
					blue_q <= 8'd0;
					alpha_q <= ALPHA_CLEAR;
					repeat_q <= data_s1;
				end
				default: begin
					red_q <= {color[15:11], 3'b000};
					green_q <= {color[10:5], 2'b00};
					blue_q <= {color[4:0], 3'b000};
					alpha_q <= semi_s1 ? ALPHA_SEMI : ALPHA_OPAQUE;
					repeat_q <= 8'd1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
	assign alpha = alpha_q;
	assign repeat_res = repeat_q;

	`RPS_ASSERT_IMP(a_trans_count, clk, arst_n, valid_s1 && kind_s1 == CMD_TRANS,
		data_s1 != 8'd0, "transparent run with zero count")
	`RPS_ASSERT_IMP(a_clear_black, clk, arst_n, out_valid_q && alpha_q == ALPHA_CLEAR,
		red_q == 8'd0 && green_q == 8'd0 && blue_q == 8'd0, "transparent word has colour")
	`RPS_ASSERT_IMP(a_pixel_single, clk, arst_n, out_valid_q && alpha_q != ALPHA_CLEAR,
		repeat_q == 8'd1, "indexed word with repeat other than one")

endmodule

`default_nettype wire

// ===== src/rle_palette_sprite_decoder.sv =====
// run-length paletted sprite decoder, top level: config registers and wiring
// path: an accepted input word goes through the command queue, the palette read stage and the output register
// throughput: one input word per cycle while the command queue is not full
// reset: asynchronous, clears parse state, queue and valid flags; markers to 0 and 1
// the palette memory is not cleared and reads undefined until written
`default_nettype none

module rle_palette_sprite_decoder
	import rps_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic opcode,
	input wire logic [7:0] stream_byte,
	input wire logic [7:0] palette_address,
	input wire logic [15:0] palette_color,
	output logic out_valid,
	input wire logic out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha,
	output logic [7:0] repeat_res,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data
);

	logic [7:0] transparent_marker_q;
	logic [7:0] semi_marker_q;

	logic push, pop, queue_full, queue_empty;
	rps_cmd_t push_cmd, pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_marker_q <= 8'd0;
			semi_marker_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRANSPARENT: transparent_marker_q <= cfg_data;
				REG_SEMI: semi_marker_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.stream_byte(stream_byte),
		.palette_address(palette_address),
		.palette_color(palette_color),
		.transparent_marker(transparent_marker_q),
		.semi_marker(semi_marker_q),
		.queue_full(queue_full),
		.push(push),
		.cmd(push_cmd)
	);

	rps_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.empty(queue_empty)
	);

	rps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(pop_cmd),
		.queue_empty(queue_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.repeat_res(repeat_res)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for the run-length paletted sprite decoder: directed runs, marker settings, random streams
// predicts each pixel word from its own palette copy and parse state and checks every field
// depends on rps_pkg and rle_palette_sprite_decoder
`default_nettype none

module tb_top
	import rps_pkg::*;
();

	typedef enum logic [1:0] {
		PM_IDLE,
		PM_TCOUNT,
		PM_SCOUNT,
		PM_RUN
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] rep;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic opcode;
	logic [7:0] stream_byte;
	logic [7:0] palette_address;
	logic [15:0] palette_color;
	logic out_valid;
	logic out_ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic [7:0] repeat_res;
	logic cfg_we;
	logic cfg_index;
	logic [7:0] cfg_data;

	pixel_t pixel_q[$];
	logic [15:0] pal_mem [PALETTE_ENTRIES];
	bit pal_valid [PALETTE_ENTRIES];
	logic [7:0] trans_marker;
	logic [7:0] semi_marker;
	parse_mode_t mode;
	logic [7:0] run_left;
	bit run_semi;
	int error_count;
	int items_sent;
	int sender_idle_pct;
	int recv_stall_pct;

	rle_palette_sprite_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.stream_byte(stream_byte),
		.palette_address(palette_address),
		.palette_color(palette_color),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.repeat_res(repeat_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic void decode_word(logic op, logic [7:0] sb, logic [7:0] addr,
			logic [15:0] color);
		pixel_t px;
		logic [15:0] c;
		if (op == OP_WRITE) begin
			pal_mem[addr] = color;
			pal_valid[addr] = 1'b1;
			return;
		end
		case (mode)
			PM_IDLE: begin
				if (sb == trans_marker) begin
					mode = PM_TCOUNT;
				end else if (sb == semi_marker) begin
					mode = PM_SCOUNT;
				end else if (sb != 8'd0) begin
					run_left = sb;
					run_semi = 1'b0;
					mode = PM_RUN;
				end
			end
			PM_TCOUNT: begin
				mode = PM_IDLE;
				if (sb != 8'd0) begin
					px.red = 8'd0;
					px.green = 8'd0;
					px.blue = 8'd0;
					px.alpha = ALPHA_CLEAR;
					px.rep = sb;
					pixel_q = {pixel_q, px};
				end
			end
			PM_SCOUNT: begin
				if (sb == 8'd0) begin
					mode = PM_IDLE;
				end else begin
					run_left = sb;
					run_semi = 1'b1;
					mode = PM_RUN;
				end
			end
			default: begin
				c = pal_mem[sb];
				px.red = {c[15:11], 3'b000};
				px.green = {c[10:5], 2'b00};
				px.blue = {c[4:0], 3'b000};
				px.alpha = run_semi ? ALPHA_SEMI : ALPHA_OPAQUE;
				px.rep = 8'd1;
				pixel_q = {pixel_q, px};
				if (run_left != 8'd0)
					run_left = run_left - 8'd1;
				if (run_left == 8'd0)
					mode = PM_IDLE;
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_index();
		logic [7:0] idx;
		idx = 8'($urandom_range(255));
		while (!pal_valid[idx])
			idx = 8'($urandom_range(255));
		return idx;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic send_word(logic op, logic [7:0] sb, logic [7:0] addr, logic [15:0] color);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		stream_byte <= sb;
		palette_address <= addr;
		palette_color <= color;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_word(op, sb, addr, color);
		items_sent++;
	endtask

	// inside a run every stream byte is an index, so keep it on a written entry
	task automatic send_stream(logic [7:0] sb);
		if (mode == PM_RUN && !pal_valid[sb])
			sb = pick_index();
		send_word(OP_STREAM, sb, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
	endtask

	task automatic send_palette(logic [7:0] addr, logic [15:0] color);
		send_word(OP_WRITE, 8'($urandom_range(255)), addr, color);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_markers(logic [7:0] t, logic [7:0] s);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TRANSPARENT;
		cfg_data <= t;
		trans_marker = t;
		@(negedge clk);
		cfg_index <= REG_SEMI;
		cfg_data <= s;
		semi_marker = s;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_basic_runs();
		send_palette(8'd0, 16'hFFFF);
		send_palette(8'd255, 16'h0000);
		send_palette(8'd1, 16'hF800);
		send_palette(8'd128, 16'h07E0);
		send_palette(8'd64, 16'h001F);
		// transparent runs of the largest count and of zero
		send_stream(8'd0);
		send_stream(8'd255);
		send_stream(8'd0);
		send_stream(8'd0);
		// semi run of two, then semi with zero count
		send_stream(8'd1);
		send_stream(8'd2);
		send_stream(8'd255);
		send_stream(8'd0);
		send_stream(8'd1);
		send_stream(8'd0);
		// opaque run with a palette write in the middle
		send_stream(8'd3);
		send_stream(8'd1);
		send_palette(8'd2, 16'hA5A5);
		send_stream(8'd128);
		send_stream(8'd2);
	endtask

	task automatic test_markers();
		// equal markers: transparent wins
		set_markers(8'd255, 8'd255);
		send_stream(8'd255);
		send_stream(8'd7);
		send_stream(8'd0);
		send_stream(8'd2);
		send_stream(8'd64);
		send_stream(8'd0);
		set_markers(8'd128, 8'd0);
		send_stream(8'd0);
		send_stream(8'd1);
		send_stream(8'd255);
		send_stream(8'd128);
		send_stream(8'd128);
	endtask

	task automatic random_phase(int n);
		int stop_at;
		int r;
		int len;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 12) begin
				send_palette(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
			end else if (r < 30) begin
				send_stream(trans_marker);
				send_stream(($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
			end else if (r < 88) begin
				if (r < 58)
					send_stream(semi_marker);
				len = ($urandom_range(63) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
				send_stream(8'(len));
				repeat (len) begin
					if ($urandom_range(9) == 0)
						send_palette(8'($urandom_range(255)),
							16'($urandom_range(16'hFFFF)));
					send_stream(pick_index());
				end
			end else if (r < 94) begin
				send_stream(8'($urandom_range(255)));
			end else begin
				send_stream(semi_marker);
				send_stream(8'd0);
			end
		end
	endtask

	task automatic test_random();
		logic [7:0] t_tab [4] = '{8'd0, 8'd255, 8'd17, 8'd200};
		logic [7:0] s_tab [4] = '{8'd1, 8'd0, 8'd17, 8'd254};
		int idle_tab [4] = '{0, 73, 0, 16};
		int stall_tab [4] = '{0, 0, 73, 16};
		for (int ph = 0; ph < 8; ph++) begin
			set_markers(t_tab[(ph + ph / 4) % 4], s_tab[(ph + ph / 4) % 4]);
			sender_idle_pct = idle_tab[ph % 4];
			recv_stall_pct = stall_tab[ph % 4];
			random_phase(205);
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				report_mismatch("pixel word with none expected, repeat", repeat_res, 8'd0);
			end else begin
				want = pixel_q.pop_front();
				if (red !== want.red)
					report_mismatch("red", red, want.red);
				if (green !== want.green)
					report_mismatch("green", green, want.green);
				if (blue !== want.blue)
					report_mismatch("blue", blue, want.blue);
				if (alpha !== want.alpha)
					report_mismatch("alpha", alpha, want.alpha);
				if (repeat_res !== want.rep)
					report_mismatch("repeat", repeat_res, want.rep);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_STREAM;
		stream_byte = 8'd0;
		palette_address = 8'd0;
		palette_color = 16'd0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TRANSPARENT;
		cfg_data = 8'd0;
		trans_marker = 8'd0;
		semi_marker = 8'd1;
		mode = PM_IDLE;
		run_left = 8'd0;
		run_semi = 1'b0;
		error_count = 0;
		items_sent = 0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_basic_runs();
		test_markers();
		test_random();
		drain_results();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
